@@ sv/acr_pkg.sv @@
// Shared types and constants for the ARP/RARP address cache.
// Used by acr_ctrl, acr_datapath and arp_cache_resolver_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int AGE_W  = 24;
  localparam int OPC_W  = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [AGE_W-1:0] TIMEOUT_RST = 24'd1000;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_OK       = 2'd1,
    ST_WAIT_MAC = 2'd2,
    ST_WAIT_IP  = 2'd3
  } entry_st_t;

  typedef enum logic [1:0] {
    MODE_RX     = 2'd0,
    MODE_LK_MAC = 2'd1,
    MODE_LK_IP  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  localparam logic [OPC_W-1:0] OP_REQ    = 16'd1;
  localparam logic [OPC_W-1:0] OP_REPLY  = 16'd2;
  localparam logic [OPC_W-1:0] OP_RREQ   = 16'd3;
  localparam logic [OPC_W-1:0] OP_RREPLY = 16'd4;

  localparam logic [2:0] FOP_NONE   = 3'd0;
  localparam logic [2:0] FOP_REQ    = 3'd1;
  localparam logic [2:0] FOP_REPLY  = 3'd2;
  localparam logic [2:0] FOP_RREQ   = 3'd3;
  localparam logic [2:0] FOP_RREPLY = 3'd4;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_ANS   = 2'd1;
  localparam logic [1:0] KIND_FAIL  = 2'd2;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_OWN_MAC = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LEARN,
    WR_WAIT,
    WR_RESOLVE,
    WR_AGE,
    WR_FREE
  } wr_op_t;

  typedef enum logic [2:0] {
    EM_OWN_FRAME,
    EM_OWN_PAIR,
    EM_HIT,
    EM_REQ,
    EM_FAIL_Q,
    EM_RESOLVED,
    EM_TIMEOUT
  } em_src_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    rec_hit;
    logic    rec_free;
    logic    idx_inc;
    wr_op_t  wr;
    logic    emit;
    em_src_t src;
    logic    flush;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  own_req;
    logic  own_rreq;
    logic  is_reply;
    logic  own_hit;
    logic  e_free;
    logic  e_learn_hit;
    logic  e_lookup_hit;
    logic  e_resolve;
    logic  e_wait;
    logic  e_age_lt;
    logic  idx_last;
    logic  n_full;
    logic  hit_found;
    logic  free_found;
    logic  pend_valid;
    logic  can_emit;
    logic  can_flush;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/acr_datapath.sv @@
// Datapath of the address cache: config registers, entry table, scan
// registers and the result staging/output words. Depends on acr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire acr_pkg::cmd_t                 cmd,
  output acr_pkg::sts_t                      sts,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [acr_pkg::OPC_W-1:0]     in_opcode,
  input  wire logic [acr_pkg::MAC_W-1:0]     in_sender_mac,
  input  wire logic [acr_pkg::IP_W-1:0]      in_sender_ip,
  input  wire logic [acr_pkg::MAC_W-1:0]     in_target_mac,
  input  wire logic [acr_pkg::IP_W-1:0]      in_target_ip,
  input  wire logic                          cfg_wr,
  input  wire logic [1:0]                    cfg_idx,
  input  wire logic [acr_pkg::DATA_W-1:0]    cfg_wdata,
  output logic [acr_pkg::DATA_W-1:0]         cfg_rdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_kind,
  output logic [2:0]                         out_opcode,
  output logic [acr_pkg::MAC_W-1:0]          out_result_mac,
  output logic [acr_pkg::IP_W-1:0]           out_result_ip,
  output logic                               out_last
);

  localparam int N = acr_pkg::TABLE_ENTRIES;

  // captured input word
  acr_pkg::mode_t                mode_r;
  logic [acr_pkg::OPC_W-1:0]     op_r;
  logic [acr_pkg::MAC_W-1:0]     smac_r, tmac_r;
  logic [acr_pkg::IP_W-1:0]      sip_r, tip_r;

  // configuration
  logic [acr_pkg::IP_W-1:0]      own_ip_r;
  logic [acr_pkg::MAC_W-1:0]     own_mac_r;
  logic [acr_pkg::AGE_W-1:0]     timeout_r;

  // table
  acr_pkg::entry_st_t            st_r [N];
  logic [acr_pkg::MAC_W-1:0]     mem_mac [N];
  logic [acr_pkg::IP_W-1:0]      mem_ip  [N];
  logic [acr_pkg::AGE_W-1:0]     mem_age [N];

  // scan
  logic [acr_pkg::IDX_W-1:0]     idx_r, hit_idx_r, free_idx_r;
  logic                          hit_found_r, free_found_r;
  logic [acr_pkg::MAC_W-1:0]     hit_mac_r;
  logic [acr_pkg::IP_W-1:0]      hit_ip_r;
  logic [acr_pkg::CNT_W-1:0]     cnt_r;
  acr_pkg::entry_st_t            rd_st_r;
  logic [acr_pkg::MAC_W-1:0]     rd_mac_r;
  logic [acr_pkg::IP_W-1:0]      rd_ip_r;
  logic [acr_pkg::AGE_W-1:0]     rd_age_r;

  // staging and output words
  logic                          pend_valid_r, pend_valid_nxt;
  logic [1:0]                    pend_kind_r;
  logic [2:0]                    pend_op_r;
  logic [acr_pkg::MAC_W-1:0]     pend_mac_r;
  logic [acr_pkg::IP_W-1:0]      pend_ip_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_kind_r;
  logic [2:0]                    out_op_r;
  logic [acr_pkg::MAC_W-1:0]     out_mac_r;
  logic [acr_pkg::IP_W-1:0]      out_ip_r;
  logic                          out_last_r;

  logic                          lk_mac;
  logic [acr_pkg::MAC_W-1:0]     res_mac, q_mac;
  logic [acr_pkg::IP_W-1:0]      res_ip, q_ip;
  logic                          out_free;

  logic                          wr_en;
  logic [acr_pkg::IDX_W-1:0]     wr_idx;
  acr_pkg::entry_st_t            wr_st;
  logic [acr_pkg::MAC_W-1:0]     wr_mac;
  logic [acr_pkg::IP_W-1:0]      wr_ip;
  logic [acr_pkg::AGE_W-1:0]     wr_age;

  logic [1:0]                    em_kind;
  logic [2:0]                    em_op;
  logic [acr_pkg::MAC_W-1:0]     em_mac;
  logic [acr_pkg::IP_W-1:0]      em_ip;

  assign lk_mac   = (mode_r == acr_pkg::MODE_LK_MAC);
  assign q_mac    = lk_mac ? '0 : tmac_r;
  assign q_ip     = lk_mac ? tip_r : '0;
  assign res_mac  = (op_r == acr_pkg::OP_REPLY) ? smac_r : rd_mac_r;
  assign res_ip   = (op_r == acr_pkg::OP_RREPLY) ? sip_r : rd_ip_r;
  assign out_free = !out_valid_r || out_ready;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
      timeout_r <= acr_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        acr_pkg::REG_OWN_IP:  own_ip_r  <= cfg_wdata[acr_pkg::IP_W-1:0];
        acr_pkg::REG_OWN_MAC: own_mac_r <= cfg_wdata[acr_pkg::MAC_W-1:0];
        acr_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata[acr_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      acr_pkg::REG_OWN_IP:  cfg_rdata = acr_pkg::DATA_W'(own_ip_r);
      acr_pkg::REG_OWN_MAC: cfg_rdata = acr_pkg::DATA_W'(own_mac_r);
      acr_pkg::REG_TIMEOUT: cfg_rdata = acr_pkg::DATA_W'(timeout_r);
      default:              cfg_rdata = '0;
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= acr_pkg::mode_t'(in_mode);
      op_r   <= in_opcode;
      smac_r <= in_sender_mac;
      sip_r  <= in_sender_ip;
      tmac_r <= in_target_mac;
      tip_r  <= in_target_ip;
    end
  end

  // table write decode
  always_comb begin
    wr_en  = 1'b1;
    wr_idx = idx_r;
    wr_st  = rd_st_r;
    wr_mac = rd_mac_r;
    wr_ip  = rd_ip_r;
    wr_age = '0;
    case (cmd.wr)
      acr_pkg::WR_LEARN: begin
        wr_idx = hit_found_r ? hit_idx_r : free_idx_r;
        wr_st  = acr_pkg::ST_OK;
        wr_mac = smac_r;
        wr_ip  = sip_r;
      end
      acr_pkg::WR_WAIT: begin
        wr_idx = free_idx_r;
        wr_st  = lk_mac ? acr_pkg::ST_WAIT_MAC : acr_pkg::ST_WAIT_IP;
        wr_mac = q_mac;
        wr_ip  = q_ip;
      end
      acr_pkg::WR_RESOLVE: begin
        wr_st  = acr_pkg::ST_OK;
        wr_mac = res_mac;
        wr_ip  = res_ip;
      end
      acr_pkg::WR_AGE: wr_age = rd_age_r + acr_pkg::AGE_W'(1);
      acr_pkg::WR_FREE: begin
        wr_st  = acr_pkg::ST_FREE;
        wr_age = rd_age_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) st_r[i] <= acr_pkg::ST_FREE;
    end else if (wr_en) begin
      st_r[wr_idx] <= wr_st;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_mac[wr_idx] <= wr_mac;
      mem_ip[wr_idx]  <= wr_ip;
      mem_age[wr_idx] <= wr_age;
    end
    if (cmd.rd) begin
      rd_st_r  <= st_r[idx_r];
      rd_mac_r <= mem_mac[idx_r];
      rd_ip_r  <= mem_ip[idx_r];
      rd_age_r <= mem_age[idx_r];
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else if (cmd.load) begin
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cmd.idx_inc) idx_r <= idx_r + acr_pkg::IDX_W'(1);
      if (cmd.rec_hit) hit_found_r <= 1'b1;
      if (cmd.rec_free) free_found_r <= 1'b1;
      if (cmd.emit) cnt_r <= cnt_r + acr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_hit) begin
      hit_idx_r <= idx_r;
      hit_mac_r <= rd_mac_r;
      hit_ip_r  <= rd_ip_r;
    end
    // keep the lowest free slot
    if (cmd.rec_free && !free_found_r) free_idx_r <= idx_r;
  end

  // result word source
  always_comb begin
    em_kind = acr_pkg::KIND_ANS;
    em_op   = acr_pkg::FOP_NONE;
    em_mac  = rd_mac_r;
    em_ip   = rd_ip_r;
    case (cmd.src)
      acr_pkg::EM_OWN_FRAME: begin
        em_kind = acr_pkg::KIND_FRAME;
        em_op   = (op_r == acr_pkg::OP_REQ) ? acr_pkg::FOP_REPLY : acr_pkg::FOP_RREPLY;
        em_mac  = smac_r;
        em_ip   = sip_r;
      end
      acr_pkg::EM_OWN_PAIR: begin
        em_mac = own_mac_r;
        em_ip  = own_ip_r;
      end
      acr_pkg::EM_HIT: begin
        em_mac = hit_mac_r;
        em_ip  = hit_ip_r;
      end
      acr_pkg::EM_REQ: begin
        em_kind = acr_pkg::KIND_FRAME;
        em_op   = lk_mac ? acr_pkg::FOP_REQ : acr_pkg::FOP_RREQ;
        em_mac  = q_mac;
        em_ip   = q_ip;
      end
      acr_pkg::EM_FAIL_Q: begin
        em_kind = acr_pkg::KIND_FAIL;
        em_mac  = q_mac;
        em_ip   = q_ip;
      end
      acr_pkg::EM_RESOLVED: begin
        em_mac = res_mac;
        em_ip  = res_ip;
      end
      default: em_kind = acr_pkg::KIND_FAIL;
    endcase
  end

  // a new word pushes the staged one out; the staged word becomes last on flush
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (cmd.emit) begin
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) out_valid_nxt = 1'b1;
    end else if (cmd.flush) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_kind_r <= em_kind;
      pend_op_r   <= em_op;
      pend_mac_r  <= em_mac;
      pend_ip_r   <= em_ip;
    end
    if ((cmd.emit && pend_valid_r) || cmd.flush) begin
      out_kind_r <= pend_kind_r;
      out_op_r   <= pend_op_r;
      out_mac_r  <= pend_mac_r;
      out_ip_r   <= pend_ip_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_opcode     = out_op_r;
  assign out_result_mac = out_mac_r;
  assign out_result_ip  = out_ip_r;
  assign out_last       = out_last_r;

  // status toward the controller
  always_comb begin
    sts.mode         = mode_r;
    sts.own_req      = (op_r == acr_pkg::OP_REQ) && (tip_r == own_ip_r);
    sts.own_rreq     = (op_r == acr_pkg::OP_RREQ) && (tmac_r == own_mac_r);
    sts.is_reply     = (op_r == acr_pkg::OP_REPLY) || (op_r == acr_pkg::OP_RREPLY);
    sts.own_hit      = lk_mac ? (tip_r == own_ip_r) : (tmac_r == own_mac_r);
    sts.e_free       = (rd_st_r == acr_pkg::ST_FREE);
    sts.e_learn_hit  = (rd_st_r == acr_pkg::ST_OK) &&
                       ((rd_ip_r == sip_r) || (rd_mac_r == smac_r));
    sts.e_lookup_hit = (rd_st_r == acr_pkg::ST_OK) &&
                       (lk_mac ? (rd_ip_r == tip_r) : (rd_mac_r == tmac_r));
    sts.e_resolve    = ((op_r == acr_pkg::OP_REPLY) && (rd_st_r == acr_pkg::ST_WAIT_MAC) &&
                        (rd_ip_r == sip_r)) ||
                       ((op_r == acr_pkg::OP_RREPLY) && (rd_st_r == acr_pkg::ST_WAIT_IP) &&
                        (rd_mac_r == smac_r));
    sts.e_wait       = (rd_st_r == acr_pkg::ST_WAIT_MAC) || (rd_st_r == acr_pkg::ST_WAIT_IP);
    sts.e_age_lt     = (rd_age_r < timeout_r);
    sts.idx_last     = (idx_r == acr_pkg::IDX_W'(N - 1));
    sts.n_full       = (cnt_r == acr_pkg::CNT_W'(acr_pkg::MAX_RESULTS));
    sts.hit_found    = hit_found_r;
    sts.free_found   = free_found_r;
    sts.pend_valid   = pend_valid_r;
    sts.can_emit     = !pend_valid_r || out_free;
    sts.can_flush    = out_free;
  end

endmodule
`default_nettype wire

@@ sv/acr_ctrl.sv @@
// Controller of the address cache: sequences decode, table scan, table
// writes and result words. Depends on acr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire acr_pkg::sts_t sts,
  output acr_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_RD, S_EV, S_FIN, S_FLUSH} state_t;
  typedef enum logic [1:0] {K_LEARN, K_LOOKUP, K_REPLY, K_TICK} scan_t;

  state_t state_r, state_nxt;
  scan_t  scan_r, scan_nxt;
  logic   hit, advance;

  assign in_ready = (state_r == S_IDLE);
  assign hit      = (scan_r == K_LEARN) ? sts.e_learn_hit : sts.e_lookup_hit;

  always_comb begin
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    cmd         = '0;
    cmd.wr      = acr_pkg::WR_NONE;
    cmd.src     = acr_pkg::EM_OWN_FRAME;
    advance     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RD;
        unique case (sts.mode)
          acr_pkg::MODE_RX: begin
            if (sts.own_req || sts.own_rreq) scan_nxt = K_LEARN;
            else if (sts.is_reply) scan_nxt = K_REPLY;
            else state_nxt = S_IDLE;
          end
          acr_pkg::MODE_LK_MAC, acr_pkg::MODE_LK_IP: begin
            if (sts.own_hit) begin
              cmd.emit  = 1'b1;
              cmd.src   = acr_pkg::EM_OWN_PAIR;
              state_nxt = S_FLUSH;
            end else begin
              scan_nxt = K_LOOKUP;
            end
          end
          default: scan_nxt = K_TICK;
        endcase
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        unique case (scan_r)
          K_LEARN, K_LOOKUP: begin
            if (hit) begin
              cmd.rec_hit = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.rec_free = sts.e_free;
              advance      = 1'b1;
            end
          end
          K_REPLY: begin
            if (sts.e_resolve && !sts.n_full) begin
              if (sts.can_emit) begin
                cmd.wr   = acr_pkg::WR_RESOLVE;
                cmd.emit = 1'b1;
                cmd.src  = acr_pkg::EM_RESOLVED;
                advance  = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            if (sts.e_wait && sts.e_age_lt) begin
              cmd.wr  = acr_pkg::WR_AGE;
              advance = 1'b1;
            end else if (sts.e_wait && !sts.n_full) begin
              // timed out: hold until the staged word can move
              if (sts.can_emit) begin
                cmd.wr   = acr_pkg::WR_FREE;
                cmd.emit = 1'b1;
                cmd.src  = acr_pkg::EM_TIMEOUT;
                advance  = 1'b1;
              end
            end else begin
              advance = 1'b1;
            end
          end
        endcase
        if (advance) begin
          if (sts.idx_last) begin
            state_nxt = ((scan_r == K_LEARN) || (scan_r == K_LOOKUP)) ? S_FIN : S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_FIN: begin
        cmd.emit  = 1'b1;
        state_nxt = S_FLUSH;
        if (scan_r == K_LEARN) begin
          cmd.src = acr_pkg::EM_OWN_FRAME;
          if (sts.hit_found || sts.free_found) cmd.wr = acr_pkg::WR_LEARN;
        end else if (sts.hit_found) begin
          cmd.src = acr_pkg::EM_HIT;
        end else if (sts.free_found) begin
          cmd.wr  = acr_pkg::WR_WAIT;
          cmd.src = acr_pkg::EM_REQ;
        end else begin
          cmd.src = acr_pkg::EM_FAIL_Q;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.can_flush) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r  <= K_LEARN;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/arp_cache_resolver_core.sv @@
// ARP/RARP address cache and responder, top level (acr_ctrl + acr_datapath).
// One item at a time: a scanning item reads, then evaluates, each table entry
// in turn between decode and flush, with a finish step before flush for learn
// and lookup; own-pair lookups skip the scan, ignored frames end after decode.
// Output waits stretch an item. Reset (synchronous, rst_n low) frees all entries
// and loads own_ip 0, own_mac 0, reply_timeout 1000; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_resolver_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [acr_pkg::OPC_W-1:0]  in_opcode,
  input  wire logic [acr_pkg::MAC_W-1:0]  in_sender_mac,
  input  wire logic [acr_pkg::IP_W-1:0]   in_sender_ip,
  input  wire logic [acr_pkg::MAC_W-1:0]  in_target_mac,
  input  wire logic [acr_pkg::IP_W-1:0]   in_target_ip,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_kind,
  output logic [2:0]                      out_opcode,
  output logic [acr_pkg::MAC_W-1:0]       out_result_mac,
  output logic [acr_pkg::IP_W-1:0]        out_result_ip,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [acr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [acr_pkg::DATA_W-1:0] pwdata,
  output logic [acr_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  acr_pkg::cmd_t cmd;
  acr_pkg::sts_t sts;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_opcode      (in_opcode),
    .in_sender_mac  (in_sender_mac),
    .in_sender_ip   (in_sender_ip),
    .in_target_mac  (in_target_mac),
    .in_target_ip   (in_target_ip),
    .cfg_wr         (cfg_wr),
    .cfg_idx        (paddr[4:3]),
    .cfg_wdata      (pwdata),
    .cfg_rdata      (prdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_opcode     (out_opcode),
    .out_result_mac (out_result_mac),
    .out_result_ip  (out_result_ip),
    .out_last       (out_last)
  );

  a_idle_no_staged: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("idle with a staged result word");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a word");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.can_emit)
    else $error("result emitted with no room");

  a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (sts.can_flush && sts.pend_valid))
    else $error("flush without room or staged word");

endmodule
`default_nettype wire

@@ sim/arp_result_checker.sv @@
// Result checker for arp_cache_resolver_core: mirrors the address table, predicts the
// result words of every accepted input word and compares them with the output channel.
// Depends on acr_pkg for field widths, opcodes, result kinds and entry states.
`timescale 1ns / 1ps
module arp_result_checker
  import acr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [MAC_W-1:0]  in_sender_mac,
  input  logic [IP_W-1:0]   in_sender_ip,
  input  logic [MAC_W-1:0]  in_target_mac,
  input  logic [IP_W-1:0]   in_target_ip,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_kind,
  input  logic [2:0]        out_opcode,
  input  logic [MAC_W-1:0]  out_result_mac,
  input  logic [IP_W-1:0]   out_result_ip,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_count
);

  typedef struct {
    logic [1:0]       kind;
    logic [2:0]       fop;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic             last;
  } arp_result_t;

  arp_result_t pending_results[$];

  logic [IP_W-1:0]  own_ip_q  = '0;
  logic [MAC_W-1:0] own_mac_q = '0;
  logic [AGE_W-1:0] timeout_q = TIMEOUT_RST;

  entry_st_t        tbl_st  [TABLE_ENTRIES];
  logic [MAC_W-1:0] tbl_mac [TABLE_ENTRIES];
  logic [IP_W-1:0]  tbl_ip  [TABLE_ENTRIES];
  logic [AGE_W-1:0] tbl_age [TABLE_ENTRIES];

  initial begin
    fail_count = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_st[i] = ST_FREE;
  end

  assign pending_count = pending_results.size();

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int first_free();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_st[i] == ST_FREE) return i;
    return -1;
  endfunction

  task automatic learn_pair(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
    int slot;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot < 0 && tbl_st[i] == ST_OK && (tbl_ip[i] == ip || tbl_mac[i] == mac)) slot = i;
    if (slot < 0) slot = first_free();
    if (slot >= 0) begin
      tbl_st[slot]  = ST_OK;
      tbl_mac[slot] = mac;
      tbl_ip[slot]  = ip;
      tbl_age[slot] = '0;
    end
  endtask

  task automatic resolve_item(mode_t m, logic [OPC_W-1:0] op,
                              logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                              logic [MAC_W-1:0] tmac, logic [IP_W-1:0] tip);
    arp_result_t res[$];
    int          slot;
    bit          by_ip;
    case (m)
      MODE_RX: begin
        if (op == OP_REQ && tip == own_ip_q) begin
          learn_pair(smac, sip);
          res.push_back('{KIND_FRAME, FOP_REPLY, smac, sip, 1'b0});
        end else if (op == OP_RREQ && tmac == own_mac_q) begin
          learn_pair(smac, sip);
          res.push_back('{KIND_FRAME, FOP_RREPLY, smac, sip, 1'b0});
        end else if (op == OP_REPLY || op == OP_RREPLY) begin
          for (int i = 0; i < TABLE_ENTRIES && res.size() < MAX_RESULTS; i++) begin
            if (op == OP_REPLY && tbl_st[i] == ST_WAIT_MAC && tbl_ip[i] == sip) begin
              tbl_mac[i] = smac;
            end else if (op == OP_RREPLY && tbl_st[i] == ST_WAIT_IP && tbl_mac[i] == smac) begin
              tbl_ip[i] = sip;
            end else begin
              continue;
            end
            tbl_st[i]  = ST_OK;
            tbl_age[i] = '0;
            res.push_back('{KIND_ANS, FOP_NONE, tbl_mac[i], tbl_ip[i], 1'b0});
          end
        end
      end
      MODE_LK_MAC, MODE_LK_IP: begin
        by_ip = (m == MODE_LK_MAC);
        if ((by_ip && tip == own_ip_q) || (!by_ip && tmac == own_mac_q)) begin
          res.push_back('{KIND_ANS, FOP_NONE, own_mac_q, own_ip_q, 1'b0});
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_st[i] == ST_OK && (by_ip ? tbl_ip[i] == tip : tbl_mac[i] == tmac)) begin
              res.push_back('{KIND_ANS, FOP_NONE, tbl_mac[i], tbl_ip[i], 1'b0});
              break;
            end
          end
          if (res.size() == 0) begin
            slot = first_free();
            if (slot < 0) begin
              res.push_back('{KIND_FAIL, FOP_NONE, by_ip ? '0 : tmac, by_ip ? tip : '0, 1'b0});
            end else begin
              tbl_st[slot]  = by_ip ? ST_WAIT_MAC : ST_WAIT_IP;
              tbl_mac[slot] = by_ip ? '0 : tmac;
              tbl_ip[slot]  = by_ip ? tip : '0;
              tbl_age[slot] = '0;
              res.push_back('{KIND_FRAME, by_ip ? FOP_REQ : FOP_RREQ,
                              tbl_mac[slot], tbl_ip[slot], 1'b0});
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_st[i] != ST_WAIT_MAC && tbl_st[i] != ST_WAIT_IP) continue;
          if (tbl_age[i] < timeout_q) begin
            tbl_age[i] = tbl_age[i] + 1'b1;
          end else if (res.size() < MAX_RESULTS) begin
            tbl_st[i] = ST_FREE;
            res.push_back('{KIND_FAIL, FOP_NONE, tbl_mac[i], tbl_ip[i], 1'b0});
          end
        end
      end
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) pending_results.push_back(res[k]);
  endtask

  task automatic compare_word();
    arp_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected word kind=%0d mac=%h ip=%h",
                       out_kind, out_result_mac, out_result_ip));
      return;
    end
    want = pending_results.pop_front();
    if (out_kind !== want.kind)
      report($sformatf("kind %0d, want %0d", out_kind, want.kind));
    if (out_opcode !== want.fop)
      report($sformatf("opcode %0d, want %0d", out_opcode, want.fop));
    if (out_result_mac !== want.mac)
      report($sformatf("mac %h, want %h", out_result_mac, want.mac));
    if (out_result_ip !== want.ip)
      report($sformatf("ip %h, want %h", out_result_ip, want.ip));
    if (out_last !== want.last)
      report($sformatf("last %b, want %b", out_last, want.last));
  endtask

  // Compare before predicting: a word leaving on the same edge belongs to an older input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) compare_word();
      if (in_valid && in_ready)
        resolve_item(mode_t'(in_mode), in_opcode, in_sender_mac, in_sender_ip,
                     in_target_mac, in_target_ip);
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_OWN_IP:  own_ip_q  = pwdata[IP_W-1:0];
          REG_OWN_MAC: own_mac_q = pwdata[MAC_W-1:0];
          REG_TIMEOUT: timeout_q = pwdata[AGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sim/tb_arp_cache_resolver_core.sv @@
// Testbench top for arp_cache_resolver_core: clock, reset, register writes, directed
// and random lookup/frame/tick traffic with random idling; checking in arp_result_checker.
// Depends on acr_pkg, arp_cache_resolver_core and arp_result_checker.
`timescale 1ns / 1ps
module tb_arp_cache_resolver_core;
  import acr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = '0;
  logic [OPC_W-1:0]  in_opcode = '0;
  logic [MAC_W-1:0]  in_sender_mac = '0;
  logic [IP_W-1:0]   in_sender_ip = '0;
  logic [MAC_W-1:0]  in_target_mac = '0;
  logic [IP_W-1:0]   in_target_ip = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [2:0]        out_opcode;
  logic [MAC_W-1:0]  out_result_mac;
  logic [IP_W-1:0]   out_result_ip;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int send_idle_pct = 38;
  int recv_idle_pct = 64;
  int sent_cnt = 0;
  logic hold_off = 1'b0;

  logic [IP_W-1:0]  own_ip_sel;
  logic [MAC_W-1:0] own_mac_sel;
  logic [IP_W-1:0]  ip_pool  [6];
  logic [MAC_W-1:0] mac_pool [6];

  arp_cache_resolver_core u_dut (.*);

  arp_result_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the output off for a long stretch so the block backs up into its input.
  initial begin
    wait (sent_cnt == 30);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic cfg_write(logic [1:0] reg_idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(reg_idx) << 3;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_station(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                             logic [AGE_W-1:0] tmo);
    own_ip_sel  = ip;
    own_mac_sel = mac;
    cfg_write(REG_OWN_IP, DATA_W'(ip));
    cfg_write(REG_OWN_MAC, DATA_W'(mac));
    cfg_write(REG_TIMEOUT, DATA_W'(tmo));
  endtask

  task automatic send_word(mode_t m, logic [OPC_W-1:0] op,
                           logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                           logic [MAC_W-1:0] tmac, logic [IP_W-1:0] tip);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_opcode     <= op;
    in_sender_mac <= smac;
    in_sender_ip  <= sip;
    in_target_mac <= tmac;
    in_target_ip  <= tip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Drain: let the checker see the last word, wait for every expected word,
  // then leave room for items that emit nothing.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  task automatic refill_pools();
    foreach (ip_pool[i]) begin
      ip_pool[i]  = $urandom;
      mac_pool[i] = rand_mac();
    end
  endtask

  task automatic random_traffic(int count);
    logic [IP_W-1:0]  pip;
    logic [MAC_W-1:0] pmac;
    int               pick;
    for (int n = 0; n < count; n++) begin
      pip  = ip_pool[$urandom_range(5)];
      pmac = mac_pool[$urandom_range(5)];
      pick = $urandom_range(99);
      if (pick < 20)
        send_word(MODE_LK_MAC, OPC_W'($urandom), rand_mac(), $urandom, rand_mac(),
                  ($urandom_range(9) == 0) ? own_ip_sel : pip);
      else if (pick < 35)
        send_word(MODE_LK_IP, OPC_W'($urandom), rand_mac(), $urandom,
                  ($urandom_range(9) == 0) ? own_mac_sel : pmac, $urandom);
      else if (pick < 55)
        send_word(MODE_RX, OP_REPLY, pmac, pip, rand_mac(), $urandom);
      else if (pick < 65)
        send_word(MODE_RX, OP_RREPLY, pmac, pip, rand_mac(), $urandom);
      else if (pick < 75)
        send_word(MODE_RX, OP_REQ, pmac, pip, rand_mac(), own_ip_sel);
      else if (pick < 80)
        send_word(MODE_RX, OP_RREQ, pmac, pip, own_mac_sel, $urandom);
      else if (pick < 92)
        send_word(MODE_TICK, OPC_W'($urandom), rand_mac(), $urandom, rand_mac(), $urandom);
      else
        send_word(mode_t'($urandom_range(3)), OPC_W'($urandom), rand_mac(), $urandom,
                  rand_mac(), $urandom);
    end
  endtask

  initial begin
    logic [IP_W-1:0]  ip_a;
    logic [MAC_W-1:0] mac_m;
    ip_a  = 32'h0A00_0005;
    mac_m = 48'h0600_1122_3344;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: own pair, miss then resolve, learning, ignored opcodes, timeout.
    set_station(32'hC0A8_0001, 48'h0200_00AA_BBCC, 24'd2);
    send_word(MODE_LK_MAC, OP_REQ, '0, '0, '0, 32'hC0A8_0001);
    send_word(MODE_LK_IP, OP_REQ, '0, '0, 48'h0200_00AA_BBCC, '0);
    send_word(MODE_LK_MAC, OP_REQ, '0, '0, '0, ip_a);
    send_word(MODE_LK_MAC, OP_REQ, '0, '0, '0, ip_a);
    send_word(MODE_LK_IP, OP_REQ, '0, '0, mac_m, '0);
    send_word(MODE_RX, OP_REPLY, 48'h0600_0000_0001, ip_a, '0, '0);
    send_word(MODE_RX, OP_RREPLY, mac_m, 32'h0A00_0009, '0, '0);
    send_word(MODE_LK_MAC, OP_REQ, '0, '0, '0, ip_a);
    send_word(MODE_LK_IP, OP_REQ, '0, '0, mac_m, '0);
    send_word(MODE_RX, OP_REQ, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hC0A8_0001);
    send_word(MODE_RX, OP_REQ, 48'h0A0B_0C0D_0E0F, 32'hFFFF_FFFF, '0, 32'hC0A8_0001);
    send_word(MODE_RX, OP_RREQ, '0, '0, 48'h0200_00AA_BBCC, '0);
    send_word(MODE_RX, OP_REQ, 48'h1, 32'h1, '0, 32'h0101_0101);
    send_word(MODE_RX, OP_RREQ, 48'h1, 32'h1, 48'h1, '0);
    send_word(MODE_RX, 16'h0000, '1, '1, '1, '1);
    send_word(MODE_RX, 16'h0005, '1, '1, '1, '1);
    send_word(MODE_RX, 16'hFFFF, '1, '1, '1, 32'hC0A8_0001);
    send_word(MODE_LK_MAC, 16'hFFFF, '1, '1, '1, 32'hFFFF_FFFF);
    send_word(MODE_LK_IP, '0, '1, '1, 48'hFFFF_FFFF_FFFF, '1);
    send_word(MODE_LK_MAC, '0, '0, '0, '0, '0);
    send_word(MODE_TICK, '0, '0, '0, '0, '0);
    send_word(MODE_TICK, '1, '1, '1, '1, '1);
    send_word(MODE_TICK, '0, '0, '0, '0, '0);
    drain();

    // Timeout at its top: waiting entries pile up and the table fills.
    set_station('1, '1, 24'hFF_FFFF);
    refill_pools();
    random_traffic(50);
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 38;
    set_station('0, '0, 24'd0);
    refill_pools();
    random_traffic(50);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_station($urandom, rand_mac(), 24'd5);
    refill_pools();
    random_traffic(50);
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
